[src/assert_macros.svh]
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, sampled on clk, off during rst.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

[src/cdem_pkg.sv]
// Types, register map and reset values for the color difference edge map.
package cdem_pkg;

  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_MAX_HEIGHT = 4096;

  localparam int CFG_AW = 5;

  typedef enum logic [2:0] {
    REG_WIDTH      = 3'd0,
    REG_HEIGHT     = 3'd1,
    REG_THRESHOLD  = 3'd2,
    REG_USE_BORDER = 3'd3,
    REG_USE_BACK   = 3'd4,
    REG_BORDER     = 3'd5,
    REG_BACK       = 3'd6
  } reg_idx_t;

  localparam logic [11:0] RST_WIDTH      = 12'd640;
  localparam logic [12:0] RST_HEIGHT     = 13'd480;
  localparam logic [9:0]  RST_THRESHOLD  = 10'd15;
  localparam logic        RST_USE_BORDER = 1'b1;
  localparam logic        RST_USE_BACK   = 1'b1;
  localparam logic [23:0] RST_BORDER     = 24'h787878;
  localparam logic [23:0] RST_BACK       = 24'hFFFFFF;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  // classification settings handed to the classifier
  typedef struct packed {
    logic [9:0] threshold;
    logic       use_border;
    logic       use_back;
    rgb_t       border;
    rgb_t       back;
  } cls_cfg_t;

  typedef struct packed {
    rgb_t color;
    logic edge_flag;
  } cls_res_t;

endpackage

[src/cdem_classify.sv]
// Edge test of one pixel against its left and lower neighbors, and color pick.
module cdem_classify (
  input  cdem_pkg::rgb_t     pix,
  input  cdem_pkg::rgb_t     left,
  input  cdem_pkg::rgb_t     down,
  input  cdem_pkg::cls_cfg_t cfg,
  output cdem_pkg::cls_res_t res
);

  function automatic logic [8:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] d;
    begin
      d = (a > b) ? {1'b0, a - b} : {1'b0, b - a};
      return d;
    end
  endfunction

  logic [9:0] sum_left;
  logic [9:0] sum_down;
  logic       edge_flag;

  always_comb begin
    sum_left = 10'(abs_diff(pix.r, left.r)) + 10'(abs_diff(pix.g, left.g)) +
               10'(abs_diff(pix.b, left.b));
    sum_down = 10'(abs_diff(pix.r, down.r)) + 10'(abs_diff(pix.g, down.g)) +
               10'(abs_diff(pix.b, down.b));
    edge_flag = (sum_left > cfg.threshold) || (sum_down > cfg.threshold);
    res.edge_flag = edge_flag;
    if (edge_flag && cfg.use_border) begin
      res.color = cfg.border;
    end else if (!edge_flag && cfg.use_back) begin
      res.color = cfg.back;
    end else begin
      res.color = pix;
    end
  end

endmodule

[src/color_difference_edge_map.sv]
// Color difference edge map: top level with line memory and output stage.
//
// Pixels enter in raster order on red/green/blue with pix_valid; a word is
// taken at a clock edge with pix_valid high and pix_stall low. Results leave
// on out_red/out_green/out_blue/is_edge/last_of_run/frame_done with res_valid
// and are taken when res_stall is low. Settings are to be written over the APB
// port only while the block is idle; the block itself does not enforce this.
// Results lag one row: pixel (r-1,c) is produced by the arrival of (r,c), and
// on the last row each pixel also yields its own result after the one above.
// The first row of a frame taller than one row yields nothing.
// The pixel that causes a result is registered by the line memory read and the
// middle stage, and the result is then registered by the output stage.
// Throughput: one pixel per cycle while res_stall is low; on the last row each
// pixel yields two words through the single output register, which stalls input.
// A res_stall holds the output word and, when the middle stage has a word,
// stops it and raises pix_stall. Reset clears counters, neighbor registers and
// settings to their defaults; the line memory is not cleared and needs no pass.
`include "assert_macros.svh"

module color_difference_edge_map #(
  parameter int MAX_WIDTH  = cdem_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = cdem_pkg::DEF_MAX_HEIGHT
) (
  input  logic                        clk,
  input  logic                        rst,
  // pixel input
  input  logic                        pix_valid,
  output logic                        pix_stall,
  input  logic [7:0]                  red,
  input  logic [7:0]                  green,
  input  logic [7:0]                  blue,
  // result output
  output logic                        res_valid,
  input  logic                        res_stall,
  output logic [7:0]                  out_red,
  output logic [7:0]                  out_green,
  output logic [7:0]                  out_blue,
  output logic                        is_edge,
  output logic                        last_of_run,
  output logic                        frame_done,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cdem_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int WCMP  = (CW + 1 > 12) ? CW + 1 : 12;
  localparam int HCMP  = (RW + 1 > 13) ? RW + 1 : 13;

  // ---------------- configuration registers ----------------
  logic [11:0]       image_width;
  logic [12:0]       image_height;
  cdem_pkg::cls_cfg_t cfg;
  cdem_pkg::reg_idx_t reg_idx;
  logic              cfg_write;

  assign pready    = 1'b1;
  assign reg_idx   = cdem_pkg::reg_idx_t'(paddr[4:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width    <= cdem_pkg::RST_WIDTH;
      image_height   <= cdem_pkg::RST_HEIGHT;
      cfg.threshold  <= cdem_pkg::RST_THRESHOLD;
      cfg.use_border <= cdem_pkg::RST_USE_BORDER;
      cfg.use_back   <= cdem_pkg::RST_USE_BACK;
      cfg.border     <= cdem_pkg::RST_BORDER;
      cfg.back       <= cdem_pkg::RST_BACK;
    end else if (cfg_write) begin
      case (reg_idx)
        cdem_pkg::REG_WIDTH:      image_width    <= pwdata[11:0];
        cdem_pkg::REG_HEIGHT:     image_height   <= pwdata[12:0];
        cdem_pkg::REG_THRESHOLD:  cfg.threshold  <= pwdata[9:0];
        cdem_pkg::REG_USE_BORDER: cfg.use_border <= pwdata[0];
        cdem_pkg::REG_USE_BACK:   cfg.use_back   <= pwdata[0];
        cdem_pkg::REG_BORDER:     cfg.border     <= pwdata[23:0];
        cdem_pkg::REG_BACK:       cfg.back       <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      cdem_pkg::REG_WIDTH:      prdata = 32'(image_width);
      cdem_pkg::REG_HEIGHT:     prdata = 32'(image_height);
      cdem_pkg::REG_THRESHOLD:  prdata = 32'(cfg.threshold);
      cdem_pkg::REG_USE_BORDER: prdata = 32'(cfg.use_border);
      cdem_pkg::REG_USE_BACK:   prdata = 32'(cfg.use_back);
      cdem_pkg::REG_BORDER:     prdata = 32'(cfg.border);
      cdem_pkg::REG_BACK:       prdata = 32'(cfg.back);
      default:                  prdata = '0;
    endcase
  end

  // ---------------- effective frame size ----------------
  logic [WCMP-1:0] width_ext;
  logic [HCMP-1:0] height_ext;
  logic [CW-1:0]   last_col_idx;
  logic [RW-1:0]   last_row_idx;

  always_comb begin
    width_ext  = WCMP'(image_width);
    height_ext = HCMP'(image_height);
    if (width_ext == '0) begin
      last_col_idx = '0;
    end else if (width_ext > WCMP'(MAX_WIDTH)) begin
      last_col_idx = CW'(MAX_WIDTH - 1);
    end else begin
      last_col_idx = CW'(width_ext - WCMP'(1));
    end
    if (height_ext == '0) begin
      last_row_idx = '0;
    end else if (height_ext > HCMP'(MAX_HEIGHT)) begin
      last_row_idx = RW'(MAX_HEIGHT - 1);
    end else begin
      last_row_idx = RW'(height_ext - HCMP'(1));
    end
  end

  // ---------------- accept stage ----------------
  logic [CW-1:0]  column_count;
  logic [RW-1:0]  row_count;
  logic [CW-1:0]  col;
  logic [RW-1:0]  row;
  logic           at_last_col;
  logic           at_last_row;
  logic           pix_accept;
  cdem_pkg::rgb_t pix_in;
  cdem_pkg::rgb_t left_pixel_current;

  assign pix_in     = '{r: red, g: green, b: blue};
  assign pix_accept = pix_valid && !pix_stall;

  always_comb begin
    col = (column_count > last_col_idx) ? last_col_idx : column_count;
    row = (row_count > last_row_idx) ? last_row_idx : row_count;
    at_last_col = (col == last_col_idx);
    at_last_row = (row == last_row_idx);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count       <= '0;
      row_count          <= '0;
      left_pixel_current <= '0;
    end else if (pix_accept) begin
      left_pixel_current <= pix_in;
      if (at_last_col) begin
        column_count <= '0;
        row_count    <= at_last_row ? '0 : row + RW'(1);
      end else begin
        column_count <= col + CW'(1);
        row_count    <= row;
      end
    end
  end

  // line memory: read-first, so the old row's pixel comes back while the
  // new one is stored at the same column
  cdem_pkg::rgb_t line_mem [MAX_WIDTH];
  cdem_pkg::rgb_t above_q;

  always_ff @(posedge clk) begin
    if (pix_accept) begin
      above_q       <= line_mem[col];
      line_mem[col] <= pix_in;
    end
  end

  // ---------------- middle stage ----------------
  logic           s1_valid;
  logic           s1_phase;
  logic           s1_above;
  logic           s1_last_row;
  logic           s1_last_col;
  logic           s1_col0;
  cdem_pkg::rgb_t s1_pix;
  cdem_pkg::rgb_t s1_left;
  cdem_pkg::rgb_t left_pixel_above;

  cdem_pkg::rgb_t     a_left;
  cdem_pkg::cls_res_t res_a;
  cdem_pkg::cls_res_t res_b;

  assign a_left = s1_col0 ? above_q : left_pixel_above;

  cdem_classify u_cls_above (
    .pix  (above_q),
    .left (a_left),
    .down (s1_pix),
    .cfg  (cfg),
    .res  (res_a)
  );

  cdem_classify u_cls_own (
    .pix  (s1_pix),
    .left (s1_left),
    .down (s1_left),
    .cfg  (cfg),
    .res  (res_b)
  );

  logic sel_a;
  logic s1_has_word;
  logic s1_word_last;
  logic out_load;
  logic s1_retire;

  always_comb begin
    sel_a        = s1_above && !s1_phase;
    s1_has_word  = s1_valid && (sel_a || s1_last_row);
    s1_word_last = !(sel_a && s1_last_row);
    out_load     = s1_has_word && (!res_valid || !res_stall);
    s1_retire    = s1_valid && (!s1_has_word || (out_load && s1_word_last));
    pix_stall    = s1_valid && !s1_retire;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid         <= 1'b0;
      s1_phase         <= 1'b0;
      left_pixel_above <= '0;
    end else begin
      if (pix_accept) begin
        s1_valid <= 1'b1;
      end else if (s1_retire) begin
        s1_valid <= 1'b0;
      end
      if (s1_retire) begin
        s1_phase <= 1'b0;
      end else if (out_load) begin
        s1_phase <= 1'b1;
      end
      if (s1_retire && s1_above) begin
        left_pixel_above <= above_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pix_accept) begin
      s1_pix      <= pix_in;
      s1_left     <= (col == '0) ? pix_in : left_pixel_current;
      s1_col0     <= (col == '0);
      s1_above    <= (row != '0);
      s1_last_row <= at_last_row;
      s1_last_col <= at_last_col;
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (sel_a) begin
        out_red    <= res_a.color.r;
        out_green  <= res_a.color.g;
        out_blue   <= res_a.color.b;
        is_edge    <= res_a.edge_flag;
        frame_done <= 1'b0;
      end else begin
        out_red    <= res_b.color.r;
        out_green  <= res_b.color.g;
        out_blue   <= res_b.color.b;
        is_edge    <= res_b.edge_flag;
        frame_done <= s1_last_col;
      end
      last_of_run <= s1_word_last;
    end
  end

  // ---------------- checks ----------------
  `ASSERT_IMPL(a_phase_only_double, s1_phase, s1_valid && s1_above && s1_last_row)
  `ASSERT_NEXT(a_accept_fills_s1, pix_accept, s1_valid)
  `ASSERT_NEXT(a_first_word_then_phase, out_load && !s1_word_last, s1_phase && s1_valid)
  `ASSERT_IMPL(a_frame_done_last, res_valid && frame_done, last_of_run)

endmodule
